### hdl/pfa_pkg.sv
package pfa_pkg;

	// default table sizes
	localparam int FRAMES_DEF = 128;
	localparam int PROCS_DEF  = 128;

	// command codes
	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_DEL  = 3'd1;
	localparam logic [2:0] CMD_STOP = 3'd2;
	localparam logic [2:0] CMD_RUN  = 3'd3;
	localparam logic [2:0] CMD_READ = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
	localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE   = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;

	// configuration registers
	localparam logic CFG_PAGE_LOG2  = 1'b0;
	localparam logic CFG_PAGE_COUNT = 1'b1;
	localparam logic [4:0] LG_RESET   = 5'd12;
	localparam logic [4:0] LG_MAX     = 5'd16;
	localparam logic [7:0] PCNT_RESET = 8'd128;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_REL, S_RLOOP, S_RLOAD, S_FIT, S_PLACE,
		S_RD1, S_RD2, S_RD3, S_DONE
	} pfa_state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_clr;
		logic       scan_step;
		logic       add_commit;
		logic       req_inc;
		logic       rel_step;
		logic       rloop_adv;
		logic       run_load;
		logic       run_take;
		logic       place_init;
		logic       place_step;
		logic       rd_frame;
		logic       rd_entry;
		logic       rd_take;
		logic       finish;
		logic [2:0] st;
	} pfa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       scan_done;
		logic       rel_done;
		logic       rloop_end;
		logic       cur_hit;
		logic       any_hit;
		logic       size_zero;
		logic       add_short;
		logic       slot_found;
		logic       fits;
		logic       place_done;
		logic       out_busy;
	} pfa_stat_t;

	// pages needed for a size at a given page size
	function automatic logic [24:0] pages_for(input logic [23:0] s, input logic [4:0] lg);
		logic [23:0] m;
		m = (24'd1 << lg) - 24'd1;
		return {1'b0, (s >> lg)} + 25'(|(s & m));
	endfunction

endpackage

### hdl/pfa_ctrl.sv
module pfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  pfa_pkg::pfa_stat_t sts,
	output pfa_pkg::pfa_cmd_t  ctl
);
	import pfa_pkg::*;

	pfa_state_t state_q, state_d;
	logic [2:0] st_q, st_d;
	logic       ran_q, ran_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			ran_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			ran_q   <= ran_d;
		end
	end

	// sequence each request
	always_comb begin
		state_d   = state_q;
		st_d      = st_q;
		ran_d     = ran_q;
		ctl       = '0;
		ctl.st    = st_q;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_DECIDE;
				else ctl.scan_step = 1'b1;
			end
			S_DECIDE: begin
				case (sts.cmd)
					CMD_ADD: begin
						ctl.req_inc = 1'b1;
						state_d     = S_DONE;
						if (sts.size_zero) st_d = ST_BAD_SIZE;
						else if (sts.add_short) st_d = ST_NO_MEMORY;
						else if (!sts.slot_found) st_d = ST_TABLE_FULL;
						else begin
							st_d           = ST_OK;
							ctl.add_commit = 1'b1;
							state_d        = S_FIT;
						end
					end
					CMD_DEL, CMD_STOP: begin
						st_d = sts.any_hit ? ST_OK : ST_NOT_FOUND;
						if (sts.any_hit) begin
							ctl.scan_clr = 1'b1;
							state_d      = S_REL;
						end else begin
							state_d = S_DONE;
						end
					end
					CMD_RUN: begin
						ctl.scan_clr = 1'b1;
						ran_d        = 1'b0;
						state_d      = S_RLOOP;
					end
					CMD_READ: state_d = S_RD1;
					default: begin
						st_d    = ST_OK;
						state_d = S_DONE;
					end
				endcase
			end
			S_REL: begin
				if (sts.rel_done) state_d = S_DONE;
				else ctl.rel_step = 1'b1;
			end
			S_RLOOP: begin
				if (sts.rloop_end) begin
					st_d    = ran_q ? ST_OK : (sts.any_hit ? ST_NO_MEMORY : ST_NOT_FOUND);
					state_d = S_DONE;
				end else if (sts.cur_hit) begin
					ctl.run_load = 1'b1;
					state_d      = S_RLOAD;
				end else begin
					ctl.rloop_adv = 1'b1;
				end
			end
			S_RLOAD: begin
				ctl.run_take = 1'b1;
				state_d      = S_FIT;
			end
			S_FIT: begin
				if (sts.fits) begin
					ctl.place_init = 1'b1;
					state_d        = S_PLACE;
				end else begin
					ctl.rloop_adv = 1'b1;
					state_d       = S_RLOOP;
				end
			end
			S_PLACE: begin
				if (!sts.place_done) begin
					ctl.place_step = 1'b1;
				end else if (sts.cmd == CMD_RUN) begin
					ran_d         = 1'b1;
					ctl.rloop_adv = 1'b1;
					state_d       = S_RLOOP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD1: begin
				ctl.rd_frame = 1'b1;
				state_d      = S_RD2;
			end
			S_RD2: begin
				ctl.rd_entry = 1'b1;
				state_d      = S_RD3;
			end
			S_RD3: begin
				ctl.rd_take = 1'b1;
				st_d        = ST_OK;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					ctl.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### hdl/pfa_dp.sv
module pfa_dp #(
	parameter int FRAMES = pfa_pkg::FRAMES_DEF,
	parameter int PROCS  = pfa_pkg::PROCS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_wdata,
	input  logic [2:0]         cmd,
	input  logic [31:0]        proc_id,
	input  logic [23:0]        size_bytes,
	input  logic [6:0]         frame_index,
	input  pfa_pkg::pfa_cmd_t  ctl,
	output pfa_pkg::pfa_stat_t sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic [23:0]        free_bytes,
	output logic               frame_is_free,
	output logic [31:0]        frame_owner,
	output logic [6:0]         frame_virt_page,
	output logic [16:0]        frame_used,
	output logic [7:0]         process_total,
	output logic [7:0]         process_running,
	output logic [31:0]        add_requests,
	output logic [31:0]        add_approved
);
	import pfa_pkg::*;

	localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int NSCAN = (FRAMES > PROCS) ? FRAMES : PROCS;
	localparam int CW    = $clog2(NSCAN + 1);
	localparam int NW    = $clog2(FRAMES + 1);
	localparam int TW    = $clog2(PROCS + 1);

	// request and configuration
	logic [2:0]  cmd_q;
	logic [31:0] id_q;
	logic [23:0] size_q;
	logic [6:0]  fidx_q;
	logic [4:0]  lg_cfg_q;
	logic [7:0]  pcnt_q;

	// scan control
	logic [CW-1:0] idx_q, pend_idx_q;
	logic          pend_v_q;
	logic [NW-1:0] nfree_q, k_q, pidx_q;
	logic [PW-1:0] slot_q, cur_slot_q;
	logic          slot_found_q, any_hit_q;
	logic [23:0]   cur_size_q;

	// flag vectors and counters
	logic [PROCS-1:0]  valid_q, ent_run_q, hit_q;
	logic [FRAMES-1:0] fr_free_q;
	logic [TW-1:0]     tot_q, runcnt_q;
	logic [31:0]       req_cnt_q, apr_cnt_q;

	// memories
	logic [31:0]   ent_id_mem   [PROCS];
	logic [23:0]   ent_size_mem [PROCS];
	logic [PW-1:0] fr_owner_mem [FRAMES];
	logic [6:0]    fr_vpage_mem [FRAMES];
	logic [16:0]   fr_bytes_mem [FRAMES];
	logic [31:0]   ent_id_rd_q;
	logic [23:0]   ent_size_rd_q;
	logic [PW-1:0] fr_owner_rd_q;
	logic [6:0]    fr_vpage_rd_q;
	logic [16:0]   fr_bytes_rd_q;

	// read-frame result and output registers
	logic        r_free_q;
	logic [31:0] r_owner_q;
	logic [6:0]  r_vpage_q;
	logic [16:0] r_used_q;
	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [23:0] free_bytes_q;
	logic        frame_is_free_q;
	logic [31:0] frame_owner_q;
	logic [6:0]  frame_virt_page_q;
	logic [16:0] frame_used_q;
	logic [7:0]  process_total_q, process_running_q;
	logic [31:0] add_requests_q, add_approved_q;

	// derived values
	logic [4:0]    lg_eff;
	logic [NW-1:0] lim;
	logic [16:0]   psize, pmask, part, bytes_w;
	logic [24:0]   need_cur, need_add, nfree_ext;
	logic [PW-1:0] idx_p, pend_p, ent_ra;
	logic [FW-1:0] idx_f, pend_f, pidx_f, fidx_f, fr_ra;
	logic          idx_in_procs, idx_in_frames, idx_below_lim, pend_below_lim;
	logic          scan_match, rel_hit, place_go, ent_re, fr_re, fidx_ok;
	logic [31:0]   fb_wide;
	logic [23:0]   fb_sat;

	assign lg_eff   = (lg_cfg_q > LG_MAX) ? LG_MAX : lg_cfg_q;
	assign lim      = (32'(pcnt_q) > FRAMES) ? NW'(FRAMES) : NW'(pcnt_q);
	assign psize    = 17'd1 << lg_eff;
	assign pmask    = psize - 17'd1;
	assign part     = cur_size_q[16:0] & pmask;
	assign need_cur = pages_for(cur_size_q, lg_eff);
	assign need_add = pages_for(size_q, lg_eff);
	assign nfree_ext = 25'(nfree_q);
	assign bytes_w  = ((25'(k_q) + 25'd1 == need_cur) && (part != 17'd0)) ? part : psize;

	assign idx_p  = idx_q[PW-1:0];
	assign idx_f  = idx_q[FW-1:0];
	assign pend_p = pend_idx_q[PW-1:0];
	assign pend_f = pend_idx_q[FW-1:0];
	assign pidx_f = pidx_q[FW-1:0];
	assign fidx_f = FW'(fidx_q);

	assign idx_in_procs   = 32'(idx_q) < PROCS;
	assign idx_in_frames  = 32'(idx_q) < FRAMES;
	assign idx_below_lim  = 32'(idx_q) < 32'(lim);
	assign pend_below_lim = 32'(pend_idx_q) < 32'(lim);
	assign fidx_ok        = 32'(fidx_q) < FRAMES;

	assign scan_match = pend_v_q && valid_q[pend_p] && (ent_id_rd_q == id_q) &&
		((cmd_q == CMD_DEL) || ((cmd_q == CMD_STOP) && ent_run_q[pend_p]) ||
		 ((cmd_q == CMD_RUN) && !ent_run_q[pend_p]));
	assign rel_hit  = pend_v_q && !fr_free_q[pend_f] && hit_q[fr_owner_rd_q];
	assign place_go = (pidx_q < lim) && (25'(k_q) < need_cur);

	assign ent_re = (ctl.scan_step && idx_in_procs) || ctl.run_load || ctl.rd_entry;
	assign ent_ra = ctl.rd_entry ? fr_owner_rd_q : idx_p;
	assign fr_re  = (ctl.rel_step && idx_in_frames) || ctl.rd_frame;
	assign fr_ra  = ctl.rd_frame ? fidx_f : idx_f;

	assign fb_wide = 32'(nfree_q) << lg_eff;
	assign fb_sat  = (|fb_wide[31:24]) ? 24'hFFFFFF : fb_wide[23:0];

	// status to controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.scan_done  = (idx_q == CW'(NSCAN)) && !pend_v_q;
		sts.rel_done   = (idx_q == CW'(FRAMES)) && !pend_v_q;
		sts.rloop_end  = idx_q == CW'(PROCS);
		sts.cur_hit    = idx_in_procs && hit_q[idx_p];
		sts.any_hit    = any_hit_q;
		sts.size_zero  = size_q == 24'd0;
		sts.add_short  = need_add > nfree_ext;
		sts.slot_found = slot_found_q;
		sts.fits       = need_cur <= nfree_ext;
		sts.place_done = !place_go;
		sts.out_busy   = rsp_valid_q && !rsp_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_cfg_q     <= LG_RESET;
			pcnt_q       <= PCNT_RESET;
			idx_q        <= '0;
			pend_idx_q   <= '0;
			pend_v_q     <= 1'b0;
			nfree_q      <= '0;
			k_q          <= '0;
			pidx_q       <= '0;
			slot_q       <= '0;
			cur_slot_q   <= '0;
			slot_found_q <= 1'b0;
			any_hit_q    <= 1'b0;
			valid_q      <= '0;
			ent_run_q    <= '0;
			hit_q        <= '0;
			fr_free_q    <= '1;
			tot_q        <= '0;
			runcnt_q     <= '0;
			req_cnt_q    <= '0;
			apr_cnt_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_index == CFG_PAGE_LOG2) lg_cfg_q <= cfg_wdata[4:0];
				else pcnt_q <= cfg_wdata;
			end
			// start a request
			if (ctl.load) begin
				nfree_q      <= '0;
				idx_q        <= '0;
				pend_v_q     <= 1'b0;
				hit_q        <= '0;
				any_hit_q    <= 1'b0;
				slot_found_q <= 1'b0;
			end
			if (ctl.scan_clr) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end
			// count free frames, find a free slot, mark matching entries
			if (ctl.scan_step) begin
				if (idx_q != CW'(NSCAN)) begin
					idx_q      <= idx_q + CW'(1);
					pend_v_q   <= idx_in_procs;
					pend_idx_q <= idx_q;
					if (idx_in_frames && idx_below_lim && fr_free_q[idx_f])
						nfree_q <= nfree_q + NW'(1);
					if (idx_in_procs && !valid_q[idx_p] && !slot_found_q) begin
						slot_found_q <= 1'b1;
						slot_q       <= idx_p;
					end
				end else begin
					pend_v_q <= 1'b0;
				end
				if (scan_match) begin
					hit_q[pend_p] <= 1'b1;
					any_hit_q     <= 1'b1;
					if (cmd_q == CMD_DEL) begin
						valid_q[pend_p] <= 1'b0;
						tot_q           <= tot_q - TW'(1);
					end
					if (ent_run_q[pend_p]) begin
						ent_run_q[pend_p] <= 1'b0;
						runcnt_q          <= runcnt_q - TW'(1);
					end
				end
			end
			// free frames owned by marked entries
			if (ctl.rel_step) begin
				if (idx_q != CW'(FRAMES)) begin
					idx_q      <= idx_q + CW'(1);
					pend_v_q   <= 1'b1;
					pend_idx_q <= idx_q;
				end else begin
					pend_v_q <= 1'b0;
				end
				if (rel_hit) begin
					fr_free_q[pend_f] <= 1'b1;
					if (pend_below_lim) nfree_q <= nfree_q + NW'(1);
				end
			end
			if (ctl.req_inc) req_cnt_q <= req_cnt_q + 32'd1;
			if (ctl.add_commit) begin
				valid_q[slot_q] <= 1'b1;
				tot_q           <= tot_q + TW'(1);
				apr_cnt_q       <= apr_cnt_q + 32'd1;
				cur_slot_q      <= slot_q;
			end
			if (ctl.rloop_adv) idx_q <= idx_q + CW'(1);
			if (ctl.run_take) cur_slot_q <= idx_p;
			if (ctl.place_init) begin
				ent_run_q[cur_slot_q] <= 1'b1;
				runcnt_q              <= runcnt_q + TW'(1);
				pidx_q                <= '0;
				k_q                   <= '0;
			end
			// hand out the lowest free frames
			if (ctl.place_step) begin
				pidx_q <= pidx_q + NW'(1);
				if (fr_free_q[pidx_f]) begin
					fr_free_q[pidx_f] <= 1'b0;
					k_q               <= k_q + NW'(1);
					nfree_q           <= nfree_q - NW'(1);
				end
			end
			// hold the response until taken
			if (ctl.finish) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// payload, memories and response
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q     <= cmd;
			id_q      <= proc_id;
			size_q    <= size_bytes;
			fidx_q    <= frame_index;
			r_free_q  <= 1'b0;
			r_owner_q <= '0;
			r_vpage_q <= '0;
			r_used_q  <= '0;
		end
		if (ent_re) begin
			ent_id_rd_q   <= ent_id_mem[ent_ra];
			ent_size_rd_q <= ent_size_mem[ent_ra];
		end
		if (ctl.add_commit) begin
			ent_id_mem[slot_q]   <= id_q;
			ent_size_mem[slot_q] <= size_q;
			cur_size_q           <= size_q;
		end
		if (ctl.run_take) cur_size_q <= ent_size_rd_q;
		if (fr_re) begin
			fr_owner_rd_q <= fr_owner_mem[fr_ra];
			fr_vpage_rd_q <= fr_vpage_mem[fr_ra];
			fr_bytes_rd_q <= fr_bytes_mem[fr_ra];
		end
		if (ctl.place_step && fr_free_q[pidx_f]) begin
			fr_owner_mem[pidx_f] <= cur_slot_q;
			fr_vpage_mem[pidx_f] <= 7'(k_q);
			fr_bytes_mem[pidx_f] <= bytes_w;
		end
		// form the read-frame result
		if (ctl.rd_take) begin
			if (!fidx_ok || fr_free_q[fidx_f]) begin
				r_free_q  <= 1'b1;
				r_owner_q <= '0;
				r_vpage_q <= '0;
				r_used_q  <= '0;
			end else begin
				r_free_q  <= 1'b0;
				r_owner_q <= valid_q[fr_owner_rd_q] ? ent_id_rd_q : 32'd0;
				r_vpage_q <= fr_vpage_rd_q;
				r_used_q  <= fr_bytes_rd_q;
			end
		end
		if (ctl.finish) begin
			status_q          <= ctl.st;
			free_bytes_q      <= fb_sat;
			frame_is_free_q   <= r_free_q;
			frame_owner_q     <= r_owner_q;
			frame_virt_page_q <= r_vpage_q;
			frame_used_q      <= r_used_q;
			process_total_q   <= (32'(tot_q) > 32'd255) ? 8'hFF : 8'(tot_q);
			process_running_q <= (32'(runcnt_q) > 32'd255) ? 8'hFF : 8'(runcnt_q);
			add_requests_q    <= req_cnt_q;
			add_approved_q    <= apr_cnt_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign free_bytes      = free_bytes_q;
	assign frame_is_free   = frame_is_free_q;
	assign frame_owner     = frame_owner_q;
	assign frame_virt_page = frame_virt_page_q;
	assign frame_used      = frame_used_q;
	assign process_total   = process_total_q;
	assign process_running = process_running_q;
	assign add_requests    = add_requests_q;
	assign add_approved    = add_approved_q;

endmodule

### hdl/paged_frame_allocator.sv
// Paged frame allocator, first fit.
// Request channel (req_valid/req_ready): cmd, proc_id, size_bytes,
// frame_index. Response channel (rsp_valid/rsp_ready): one response per
// request with status, free bytes, read-frame fields, process counts and
// add counters. Configuration: cfg_we writes cfg_wdata to register
// cfg_index (0 page size log2, 1 page count) with no wait; write only idle.
// One request is in work at a time. Every request first walks
// max(FRAMES, PROCS) slots one per cycle to count free frames and match
// entries. Delete and stop then, if an entry matched, walk FRAMES frames to
// free them; run walks PROCS slots and scans frames one per cycle for each
// entry it places; add places its entry the same way; read frame reads the
// frame, then its owner entry, then forms the result. The single-port entry
// and frame memories set this pace. A new request is taken while the previous
// response still waits; a stalled response holds its values, and the next one
// waits until it is taken. Reset clears all flags and counters at once: all
// frames free, no entries, registers at page size 4096 and 128 frames.
module paged_frame_allocator #(
	parameter int FRAMES = pfa_pkg::FRAMES_DEF,
	parameter int PROCS  = pfa_pkg::PROCS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] proc_id,
	input  logic [23:0] size_bytes,
	input  logic [6:0]  frame_index,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [23:0] free_bytes,
	output logic        frame_is_free,
	output logic [31:0] frame_owner,
	output logic [6:0]  frame_virt_page,
	output logic [16:0] frame_used,
	output logic [7:0]  process_total,
	output logic [7:0]  process_running,
	output logic [31:0] add_requests,
	output logic [31:0] add_approved
);
	import pfa_pkg::*;

	pfa_cmd_t  ctl;
	pfa_stat_t sts;

	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pfa_dp #(
		.FRAMES (FRAMES),
		.PROCS  (PROCS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.cmd             (cmd),
		.proc_id         (proc_id),
		.size_bytes      (size_bytes),
		.frame_index     (frame_index),
		.ctl             (ctl),
		.sts             (sts),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.status          (status),
		.free_bytes      (free_bytes),
		.frame_is_free   (frame_is_free),
		.frame_owner     (frame_owner),
		.frame_virt_page (frame_virt_page),
		.frame_used      (frame_used),
		.process_total   (process_total),
		.process_running (process_running),
		.add_requests    (add_requests),
		.add_approved    (add_approved)
	);

endmodule

### hdl/pfa_checker.sv
module pfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  status,
	input logic [23:0] free_bytes,
	input logic        frame_is_free,
	input logic [31:0] frame_owner,
	input logic [6:0]  frame_virt_page,
	input logic [16:0] frame_used,
	input logic [7:0]  process_total,
	input logic [7:0]  process_running
);
	import pfa_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(free_bytes))
		else $error("stalled response changed");

	// status is a defined code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_NOT_FOUND ||
			status == ST_NO_MEMORY || status == ST_BAD_SIZE || status == ST_TABLE_FULL))
		else $error("undefined status code");

	// a free frame reports no mapping
	a_free_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && frame_is_free |->
			frame_owner == 32'd0 && frame_virt_page == 7'd0 && frame_used == 17'd0)
		else $error("free frame reports a mapping");

	// running entries are a subset of held entries
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> process_running <= process_total)
		else $error("running count above total");

endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (.*);
